>>> hdl/sru_pkg.sv
`timescale 1ns / 1ps

package sru_pkg;

	// Store capacity and derived widths
	localparam int unsigned MAX_ITEMS = 64;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
	localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic signed [DATA_W-1:0] value_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [CNT_W-1:0]         count_t;

	// Controls into the shared compare unit
	typedef struct packed {
		logic have_prev;
		logic best_vld;
	} cmp_ctrl_t;

endpackage

>>> hdl/sru_ram.sv
`timescale 1ns / 1ps

module sru_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, read one word with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/sru_cmp.sv
`timescale 1ns / 1ps

module sru_cmp
	import sru_pkg::*;
(
	input  value_t    cand,
	input  value_t    prev,
	input  value_t    best,
	input  cmp_ctrl_t ctrl,
	output logic      take
);

	logic above_prev;
	logic below_best;

	// Keep a word only if it is above the last value found (when there is one) and below the current best (when valid)
	always_comb begin
		above_prev = !ctrl.have_prev || (cand > prev);
		below_best = !ctrl.best_vld || (cand < best);
		take       = above_prev && below_best;
	end

endmodule

>>> hdl/sort_and_remove_duplicates_top.sv
`timescale 1ns / 1ps

// Sort-unique block. Words of a set are loaded one per cycle into a 64-entry
// store in arrival order; words beyond capacity are dropped and flag overflow
// on every result of that set. After the word marked last_in, the block stops
// taking input and runs passes over the store with one compare unit and one
// RAM read port: each pass reads every stored word and finds the smallest
// value above the one found before. After the pass that finds no value and
// any output stall, in_ready rises again. Results come out in ascending
// signed order, each distinct value once, with last_out on the final one;
// the output register lets the block start the next set while the final
// result still waits to be taken.
module sort_and_remove_duplicates_top
	import sru_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  value_t value,
	input  logic   last_in,
	output logic   out_valid,
	input  logic   out_ready,
	output value_t unique_value,
	output logic   last_out,
	output logic   overflow
);

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_SCAN = 3'b010,
		ST_PUT  = 3'b100
	} state_t;

	state_t    state_q;
	count_t    cnt_q;
	logic      drop_q;
	logic      have_prev_q;
	logic      best_vld_q;
	logic      pend_vld_q;
	count_t    rd_addr_q;
	logic      rd_vld_q;
	logic      out_vld_q;
	value_t    prev_q;
	value_t    best_q;
	value_t    pend_q;
	value_t    out_val_q;
	logic      out_last_q;
	logic      out_ovf_q;

	logic      in_fire;
	logic      store_room;
	logic      rd_issue;
	logic      scan_end;
	logic      out_free;
	logic      put_go;
	logic      emit;
	logic      take;
	value_t    rd_data;
	cmp_ctrl_t cmp_ctrl;

	// Handshake and sequencer decode
	always_comb begin
		in_ready   = (state_q == ST_LOAD);
		in_fire    = in_valid && in_ready;
		store_room = (cnt_q < count_t'(MAX_ITEMS));
		rd_issue   = (state_q == ST_SCAN) && (rd_addr_q < cnt_q);
		scan_end   = (state_q == ST_SCAN) && (rd_addr_q == cnt_q) && !rd_vld_q;
		out_free   = !out_vld_q || out_ready;
		put_go     = (state_q == ST_PUT) && (out_free || !pend_vld_q);
		emit       = put_go && pend_vld_q;
		cmp_ctrl.have_prev = have_prev_q;
		cmp_ctrl.best_vld  = best_vld_q;
	end

	// Value store
	sru_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (in_fire && store_room),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(value),
		.raddr(rd_addr_q[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	// Shared compare unit
	sru_cmp u_cmp (
		.cand(rd_data),
		.prev(prev_q),
		.best(best_q),
		.ctrl(cmp_ctrl),
		.take(take)
	);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			have_prev_q <= 1'b0;
			best_vld_q  <= 1'b0;
			pend_vld_q  <= 1'b0;
			rd_addr_q   <= '0;
			rd_vld_q    <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (store_room) begin
							cnt_q <= cnt_q + count_t'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (last_in) begin
							state_q     <= ST_SCAN;
							rd_addr_q   <= '0;
							rd_vld_q    <= 1'b0;
							have_prev_q <= 1'b0;
							best_vld_q  <= 1'b0;
							pend_vld_q  <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					// advance the read pointer and score the word that returns
					rd_vld_q <= rd_issue;
					if (rd_issue) begin
						rd_addr_q <= rd_addr_q + count_t'(1);
					end
					if (rd_vld_q && take) begin
						best_vld_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (put_go) begin
						if (best_vld_q) begin
							// hold the new value until the next pass shows whether it is final
							pend_vld_q  <= 1'b1;
							have_prev_q <= 1'b1;
							best_vld_q  <= 1'b0;
							rd_addr_q   <= '0;
							state_q     <= ST_SCAN;
						end else begin
							// nothing left: drop the set
							pend_vld_q  <= 1'b0;
							have_prev_q <= 1'b0;
							cnt_q       <= '0;
							drop_q      <= 1'b0;
							state_q     <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && rd_vld_q && take) begin
			best_q <= rd_data;
		end
		if (put_go) begin
			prev_q <= best_q;
			pend_q <= best_q;
		end
		if (emit) begin
			out_val_q  <= pend_q;
			out_last_q <= !best_vld_q;
			out_ovf_q  <= drop_q;
		end
	end

	assign out_valid    = out_vld_q;
	assign unique_value = out_val_q;
	assign last_out     = out_last_q;
	assign overflow     = out_ovf_q;

	// Fill count never passes capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= count_t'(MAX_ITEMS))
		else $error("fill count above capacity");

	// A set that starts sorting always holds a stored word
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last_in) |=> (cnt_q != '0))
		else $error("empty set entered sort");

	// The final result always has a pending value to carry
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_PUT) && !best_vld_q) |-> pend_vld_q)
		else $error("set ended with no pending value");

	// Read data only returns during a scan
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> (state_q == ST_SCAN))
		else $error("read return outside scan");

endmodule
